[hdl/midpoint_circle_rasterizer_assert.svh]
// Assertion macros used by the circle rasterizer checker.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mcr_pkg.sv]
package mcr_pkg;

    // Field widths
    localparam int CENTER_W   = 11;
    localparam int RADIUS_W   = 6;
    localparam int COORD_W    = 13;
    localparam int CANVAS_W   = 11;
    localparam int MASK_W     = 8;
    localparam int GEN_W      = 8;
    localparam int DEC_W      = 12;

    // Generator limits
    localparam int MAX_RADIUS = 63;
    localparam int STEP_CAP   = 64;
    localparam int CNT_W      = $clog2(STEP_CAP);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CANVAS_W;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;
    localparam logic [CANVAS_W-1:0]  CANVAS_RESET      = 11'd800;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } mcr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

[hdl/mcr_cmd_if.sv]
interface mcr_cmd_if;
    import mcr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RADIUS_W-1:0] radius;
    logic                paint_red;

    modport source (output valid, center_x, center_y, radius, paint_red, input ready);
    modport sink   (input valid, center_x, center_y, radius, paint_red, output ready);
endinterface

[hdl/mcr_step_if.sv]
interface mcr_step_if;
    import mcr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] col_plus_gx;
    logic signed [COORD_W-1:0] col_minus_gx;
    logic signed [COORD_W-1:0] col_plus_gy;
    logic signed [COORD_W-1:0] col_minus_gy;
    logic signed [COORD_W-1:0] row_plus_gx;
    logic signed [COORD_W-1:0] row_minus_gx;
    logic signed [COORD_W-1:0] row_plus_gy;
    logic signed [COORD_W-1:0] row_minus_gy;
    logic [MASK_W-1:0]         inside_mask;
    logic                      paint_red_out;
    logic                      last_step;

    modport source (
        output valid, col_plus_gx, col_minus_gx, col_plus_gy, col_minus_gy,
               row_plus_gx, row_minus_gx, row_plus_gy, row_minus_gy,
               inside_mask, paint_red_out, last_step,
        input  ready
    );
    modport sink (
        input  valid, col_plus_gx, col_minus_gx, col_plus_gy, col_minus_gy,
               row_plus_gx, row_minus_gx, row_plus_gy, row_minus_gy,
               inside_mask, paint_red_out, last_step,
        output ready
    );
endinterface

[hdl/mcr_datapath.sv]
module mcr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  mcr_pkg::dp_cmd_t                  dp_cmd,
    output mcr_pkg::dp_status_t               dp_status,
    input  logic [mcr_pkg::CENTER_W-1:0]      center_x,
    input  logic [mcr_pkg::CENTER_W-1:0]      center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]      radius,
    input  logic                              paint_red,
    output logic signed [mcr_pkg::COORD_W-1:0] col_plus_gx,
    output logic signed [mcr_pkg::COORD_W-1:0] col_minus_gx,
    output logic signed [mcr_pkg::COORD_W-1:0] col_plus_gy,
    output logic signed [mcr_pkg::COORD_W-1:0] col_minus_gy,
    output logic signed [mcr_pkg::COORD_W-1:0] row_plus_gx,
    output logic signed [mcr_pkg::COORD_W-1:0] row_minus_gx,
    output logic signed [mcr_pkg::COORD_W-1:0] row_plus_gy,
    output logic signed [mcr_pkg::COORD_W-1:0] row_minus_gy,
    output logic [mcr_pkg::MASK_W-1:0]        inside_mask,
    output logic                              paint_red_out
);
    import mcr_pkg::*;

    logic [CANVAS_W-1:0]      width_reg, width_next;
    logic [CANVAS_W-1:0]      height_reg, height_next;
    logic signed [GEN_W-1:0]  gx_reg, gx_next;
    logic signed [GEN_W-1:0]  gy_reg, gy_next;
    logic signed [DEC_W-1:0]  dec_reg, dec_next;
    logic [CENTER_W-1:0]      cx_reg, cx_next;
    logic [CENTER_W-1:0]      cy_reg, cy_next;
    logic                     red_reg, red_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic [RADIUS_W-1:0]      r_sat;
    logic signed [GEN_W-1:0]  gx_inc;
    logic signed [GEN_W-1:0]  gy_dec;
    logic signed [DEC_W-1:0]  gx_inc_ext;
    logic signed [DEC_W-1:0]  gy_dec_ext;
    logic signed [COORD_W-1:0] cx_ext, cy_ext, gx_ext, gy_ext;

    function automatic logic in_canvas(
        input logic signed [COORD_W-1:0] col,
        input logic signed [COORD_W-1:0] row,
        input logic [CANVAS_W-1:0]       lim_w,
        input logic [CANVAS_W-1:0]       lim_h
    );
        logic signed [COORD_W-1:0] w_ext;
        logic signed [COORD_W-1:0] h_ext;
        w_ext = $signed({{(COORD_W-CANVAS_W){1'b0}}, lim_w});
        h_ext = $signed({{(COORD_W-CANVAS_W){1'b0}}, lim_h});
        return !col[COORD_W-1] && !row[COORD_W-1] && (col < w_ext) && (row < h_ext);
    endfunction

    // Configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:  width_next  = cfg_wdata;
                REG_CANVAS_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Midpoint recurrence: load a command or advance one step
    always_comb
    begin
        r_sat = (radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;
        gx_inc = gx_reg + GEN_W'(1);
        gy_dec = gy_reg - GEN_W'(1);
        gx_inc_ext = {{(DEC_W-GEN_W){gx_inc[GEN_W-1]}}, gx_inc};
        gy_dec_ext = {{(DEC_W-GEN_W){gy_dec[GEN_W-1]}}, gy_dec};

        gx_next  = gx_reg;
        gy_next  = gy_reg;
        dec_next = dec_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        red_next = red_reg;
        cnt_next = cnt_reg;

        if (dp_cmd.load)
        begin
            gx_next  = '0;
            gy_next  = $signed({{(GEN_W-RADIUS_W){1'b0}}, r_sat});
            dec_next = DEC_W'(3) - $signed({{(DEC_W-RADIUS_W-1){1'b0}}, r_sat, 1'b0});
            cx_next  = center_x;
            cy_next  = center_y;
            red_next = paint_red;
            cnt_next = '0;
        end
        else if (dp_cmd.advance)
        begin
            gx_next  = gx_inc;
            cnt_next = cnt_reg + CNT_W'(1);
            if (dec_reg > 0)
            begin
                gy_next  = gy_dec;
                dec_next = dec_reg + ((gx_inc_ext - gy_dec_ext) <<< 2) + DEC_W'(10);
            end
            else
            begin
                dec_next = dec_reg + (gx_inc_ext <<< 2) + DEC_W'(6);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CANVAS_RESET;
            height_reg <= CANVAS_RESET;
            gx_reg     <= '0;
            gy_reg     <= '0;
            dec_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            red_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            gx_reg     <= gx_next;
            gy_reg     <= gy_next;
            dec_reg    <= dec_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            red_reg    <= red_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Stop after the point that leaves the octant, or at the step cap
    assign dp_status.last = (gy_reg < gx_reg) || (cnt_reg == CNT_W'(STEP_CAP - 1));

    // Symmetric coordinates of the current point
    assign cx_ext = $signed({{(COORD_W-CENTER_W){1'b0}}, cx_reg});
    assign cy_ext = $signed({{(COORD_W-CENTER_W){1'b0}}, cy_reg});
    assign gx_ext = {{(COORD_W-GEN_W){gx_reg[GEN_W-1]}}, gx_reg};
    assign gy_ext = {{(COORD_W-GEN_W){gy_reg[GEN_W-1]}}, gy_reg};

    assign col_plus_gx  = cx_ext + gx_ext;
    assign col_minus_gx = cx_ext - gx_ext;
    assign col_plus_gy  = cx_ext + gy_ext;
    assign col_minus_gy = cx_ext - gy_ext;
    assign row_plus_gx  = cy_ext + gx_ext;
    assign row_minus_gx = cy_ext - gx_ext;
    assign row_plus_gy  = cy_ext + gy_ext;
    assign row_minus_gy = cy_ext - gy_ext;

    // Clip each of the eight points against the canvas
    assign inside_mask[0] = in_canvas(col_plus_gx,  row_plus_gy,  width_reg, height_reg);
    assign inside_mask[1] = in_canvas(col_minus_gx, row_plus_gy,  width_reg, height_reg);
    assign inside_mask[2] = in_canvas(col_plus_gx,  row_minus_gy, width_reg, height_reg);
    assign inside_mask[3] = in_canvas(col_minus_gx, row_minus_gy, width_reg, height_reg);
    assign inside_mask[4] = in_canvas(col_plus_gy,  row_plus_gx,  width_reg, height_reg);
    assign inside_mask[5] = in_canvas(col_minus_gy, row_plus_gx,  width_reg, height_reg);
    assign inside_mask[6] = in_canvas(col_plus_gy,  row_minus_gx, width_reg, height_reg);
    assign inside_mask[7] = in_canvas(col_minus_gy, row_minus_gx, width_reg, height_reg);

    assign paint_red_out = red_reg;

endmodule

[hdl/mcr_ctrl.sv]
module mcr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    output logic                 step_valid,
    input  logic                 step_ready,
    output mcr_pkg::dp_cmd_t     dp_cmd,
    input  mcr_pkg::dp_status_t  dp_status
);
    import mcr_pkg::*;

    mcr_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (step_ready && dp_status.last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_ready      = 1'b0;
        step_valid     = 1'b0;
        dp_cmd.load    = 1'b0;
        dp_cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready   = 1'b1;
                dp_cmd.load = cmd_valid;
            end
            ST_EMIT:
            begin
                step_valid     = 1'b1;
                dp_cmd.advance = step_ready && !dp_status.last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/midpoint_circle_rasterizer.sv]
// The first step of a circle is presented in the cycle after its command transaction.
// Throughput: one step per cycle while the sink is ready; radius r gives about r/sqrt2 + 2
// steps (46 at radius 63), set by the single generator register set advancing once a cycle.
// A new command is taken in the cycle after the last step leaves.
// Reset: asynchronous active low; block idle, canvas limits 800 by 800, generator cleared.
module midpoint_circle_rasterizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    mcr_cmd_if.sink                        cmd,
    mcr_step_if.source                     step
);
    import mcr_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequence circle commands and step transactions
    mcr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .step_valid (step.valid),
        .step_ready (step.ready),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status)
    );

    // Generator, coordinate and clipping logic
    mcr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .center_x      (cmd.center_x),
        .center_y      (cmd.center_y),
        .radius        (cmd.radius),
        .paint_red     (cmd.paint_red),
        .col_plus_gx   (step.col_plus_gx),
        .col_minus_gx  (step.col_minus_gx),
        .col_plus_gy   (step.col_plus_gy),
        .col_minus_gy  (step.col_minus_gy),
        .row_plus_gx   (step.row_plus_gx),
        .row_minus_gx  (step.row_minus_gx),
        .row_plus_gy   (step.row_plus_gy),
        .row_minus_gy  (step.row_minus_gy),
        .inside_mask   (step.inside_mask),
        .paint_red_out (step.paint_red_out)
    );

    assign step.last_step = dp_status.last;

endmodule

[hdl/mcr_checker.sv]
`include "midpoint_circle_rasterizer_assert.svh"

module mcr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              step_valid,
    input logic                              step_ready,
    input logic                              last_step,
    input logic signed [mcr_pkg::COORD_W-1:0] col_plus_gx,
    input logic [mcr_pkg::MASK_W-1:0]        inside_mask
);
    // A command transaction is followed at once by its first step
    `MCR_ASSERT_NEXT(a_cmd_to_step, clk, rst_n, cmd_valid && cmd_ready, step_valid && !cmd_ready, "no step after command")

    // No command is taken while steps are outstanding
    `MCR_ASSERT_IMPL(a_one_circle, clk, rst_n, step_valid, !cmd_ready, "command ready during a circle")

    // Steps of one circle run without gaps
    `MCR_ASSERT_NEXT(a_steps_run, clk, rst_n, step_valid && step_ready && !last_step, step_valid, "gap inside a circle")

    // The last step returns the block to idle
    `MCR_ASSERT_NEXT(a_last_idle, clk, rst_n, step_valid && step_ready && last_step, cmd_ready && !step_valid, "not idle after last step")

    // A stalled step holds its payload
    `MCR_ASSERT_NEXT(a_stall_hold, clk, rst_n, step_valid && !step_ready, step_valid && $stable(col_plus_gx) && $stable(inside_mask) && $stable(last_step), "stalled step changed")

endmodule

bind midpoint_circle_rasterizer mcr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .step_valid  (step.valid),
    .step_ready  (step.ready),
    .last_step   (step.last_step),
    .col_plus_gx (step.col_plus_gx),
    .inside_mask (step.inside_mask)
);

[tb/midpoint_circle_rasterizer_checker.sv]
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_checker
    import mcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    mcr_cmd_if                    cmd,
    mcr_step_if                   step,
    output int                    mismatch_count,
    output int                    steps_pending
);

    // One midpoint step as seen on the output channel
    typedef struct packed {
        logic [7:0][COORD_W-1:0] coord;
        logic [MASK_W-1:0]       mask;
        logic                    red;
        logic                    last;
    } circle_step_t;

    circle_step_t expected_steps [$];

    logic [CANVAS_W-1:0] canvas_w;
    logic [CANVAS_W-1:0] canvas_h;

    string coord_name [8] = '{"col_plus_gx", "col_minus_gx", "col_plus_gy", "col_minus_gy",
                              "row_plus_gx", "row_minus_gx", "row_plus_gy", "row_minus_gy"};

    initial mismatch_count = 0;

    function automatic logic in_canvas(input int col, input int row);
        return col >= 0 && row >= 0 && col < int'(canvas_w) && row < int'(canvas_h);
    endfunction

    // Walk the whole octant for one circle command and queue every step
    function automatic void predict_circle(input logic [CENTER_W-1:0] cx_in,
                                           input logic [CENTER_W-1:0] cy_in,
                                           input logic [RADIUS_W-1:0] rad_in,
                                           input logic                red);
        int           cx;
        int           cy;
        int           gx;
        int           gy;
        int           dec;
        int           count;
        int           cpx, cmx, cpy, cmy, rpx, rmx, rpy, rmy;
        circle_step_t s;
        cx    = int'(cx_in);
        cy    = int'(cy_in);
        gy    = (int'(rad_in) > MAX_RADIUS) ? MAX_RADIUS : int'(rad_in);
        gx    = 0;
        dec   = 3 - 2 * gy;
        count = 0;
        do
        begin
            // Advance the generator on every step after the first
            if (count > 0)
            begin
                gx++;
                if (dec > 0)
                begin
                    gy--;
                    dec += 4 * (gx - gy) + 10;
                end
                else
                begin
                    dec += 4 * gx + 6;
                end
            end
            cpx = cx + gx;
            cmx = cx - gx;
            cpy = cx + gy;
            cmy = cx - gy;
            rpx = cy + gx;
            rmx = cy - gx;
            rpy = cy + gy;
            rmy = cy - gy;
            s.coord[0] = COORD_W'(cpx);
            s.coord[1] = COORD_W'(cmx);
            s.coord[2] = COORD_W'(cpy);
            s.coord[3] = COORD_W'(cmy);
            s.coord[4] = COORD_W'(rpx);
            s.coord[5] = COORD_W'(rmx);
            s.coord[6] = COORD_W'(rpy);
            s.coord[7] = COORD_W'(rmy);
            s.mask[0]  = in_canvas(cpx, rpy);
            s.mask[1]  = in_canvas(cmx, rpy);
            s.mask[2]  = in_canvas(cpx, rmy);
            s.mask[3]  = in_canvas(cmx, rmy);
            s.mask[4]  = in_canvas(cpy, rpx);
            s.mask[5]  = in_canvas(cmy, rpx);
            s.mask[6]  = in_canvas(cpy, rmx);
            s.mask[7]  = in_canvas(cmy, rmx);
            s.red      = red;
            s.last     = !(gy >= gx && count + 1 < STEP_CAP);
            expected_steps = {expected_steps, s};
            count++;
        end
        while (gy >= gx && count < STEP_CAP);
    endfunction

    // Compare one received step against the oldest prediction
    task automatic check_step(input circle_step_t want, input circle_step_t got);
        for (int k = 0; k < 8; k++)
        begin
            if (want.coord[k] !== got.coord[k])
            begin
                $display("%0t: %s expected %0d actual %0d", $time, coord_name[k],
                         $signed(want.coord[k]), $signed(got.coord[k]));
                mismatch_count++;
            end
        end
        if (want.mask !== got.mask)
        begin
            $display("%0t: inside_mask expected %b actual %b", $time, want.mask, got.mask);
            mismatch_count++;
        end
        if (want.red !== got.red)
        begin
            $display("%0t: paint_red_out expected %b actual %b", $time, want.red, got.red);
            mismatch_count++;
        end
        if (want.last !== got.last)
        begin
            $display("%0t: last_step expected %b actual %b", $time, want.last, got.last);
            mismatch_count++;
        end
    endtask

    // Track the canvas registers, predict on each command, check each step
    always @(posedge clk or negedge rst_n)
    begin
        circle_step_t got;
        if (!rst_n)
        begin
            canvas_w = CANVAS_RESET;
            canvas_h = CANVAS_RESET;
            expected_steps.delete();
            steps_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CANVAS_WIDTH:  canvas_w = cfg_wdata;
                    REG_CANVAS_HEIGHT: canvas_h = cfg_wdata;
                    default: ;
                endcase
            end
            if (step.valid && step.ready)
            begin
                got.coord[0] = step.col_plus_gx;
                got.coord[1] = step.col_minus_gx;
                got.coord[2] = step.col_plus_gy;
                got.coord[3] = step.col_minus_gy;
                got.coord[4] = step.row_plus_gx;
                got.coord[5] = step.row_minus_gx;
                got.coord[6] = step.row_plus_gy;
                got.coord[7] = step.row_minus_gy;
                got.mask     = step.inside_mask;
                got.red      = step.paint_red_out;
                got.last     = step.last_step;
                if (expected_steps.size() == 0)
                begin
                    $display("%0t: step transaction with no step expected, actual %p",
                             $time, got);
                    mismatch_count++;
                end
                else
                begin
                    check_step(expected_steps.pop_front(), got);
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_circle(cmd.center_x, cmd.center_y, cmd.radius, cmd.paint_red);
            end
            steps_pending = expected_steps.size();
        end
    end

endmodule

[tb/midpoint_circle_rasterizer_tb.sv]
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_tb;
    import mcr_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 34;
    localparam int PHASES      = 6;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatch_count;
    int                    steps_pending;
    int                    idle_cycles;
    int                    cur_w;
    int                    cur_h;

    mcr_cmd_if  cmd_ch ();
    mcr_step_if step_ch ();

    midpoint_circle_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch.sink),
        .step      (step_ch.source)
    );

    midpoint_circle_rasterizer_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd_ch),
        .step           (step_ch),
        .mismatch_count (mismatch_count),
        .steps_pending  (steps_pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Centre coordinate: full range, near the clip limit, or near zero
    function automatic logic [CENTER_W-1:0] pick_coord(input int limit);
        int mode;
        mode = $urandom_range(0, 3);
        case (mode)
            0, 1:    return CENTER_W'($urandom);
            2:       return CENTER_W'(limit + int'($urandom_range(0, 140)) - 70);
            default: return CENTER_W'($urandom_range(0, 70));
        endcase
    endfunction

    // Present one circle command and hold it until the transaction
    task automatic send_circle(input logic [CENTER_W-1:0] x, input logic [CENTER_W-1:0] y,
                               input logic [RADIUS_W-1:0] r, input logic red);
        int gap;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.center_x  <= x;
        cmd_ch.center_y  <= y;
        cmd_ch.radius    <= r;
        cmd_ch.paint_red <= red;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every predicted step has come out
    task automatic wait_circles_done();
        if (cmd_ch.valid)
            cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (steps_pending != 0);
        repeat (4) @(negedge clk);
    endtask

    // Write both clip limits while the block is idle
    task automatic set_canvas(input int w, input int h);
        wait_circles_done();
        cfg_we    <= 1'b1;
        cfg_index <= REG_CANVAS_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(negedge clk);
        cfg_index <= REG_CANVAS_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // Sink side: ready runs broken by random stalls
    initial
    begin
        int run;
        int gap;
        step_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            step_ch.ready <= 1'b1;
            repeat (run) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                step_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (step_ch.valid && step_ch.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** midpoint_circle_rasterizer: FAILED **");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        cmd_ch.valid     = 1'b0;
        cmd_ch.center_x  = '0;
        cmd_ch.center_y  = '0;
        cmd_ch.radius    = '0;
        cmd_ch.paint_red = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_CANVAS_WIDTH;
        cfg_wdata        = '0;
        rst_n            = 1'b0;
        cur_w            = int'(CANVAS_RESET);
        cur_h            = int'(CANVAS_RESET);
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed circles on the reset canvas: zero radius, largest radius,
        // centres at the field extremes and on the clip edges
        send_circle(11'd0,    11'd0,    6'd0,  1'b0);
        send_circle(11'd0,    11'd0,    6'd63, 1'b1);
        send_circle(11'd2047, 11'd2047, 6'd63, 1'b0);
        send_circle(11'd2047, 11'd0,    6'd1,  1'b1);
        send_circle(11'd0,    11'd2047, 6'd1,  1'b0);
        send_circle(11'd400,  11'd400,  6'd63, 1'b1);
        send_circle(11'd799,  11'd799,  6'd10, 1'b0);
        send_circle(11'd800,  11'd800,  6'd5,  1'b1);
        send_circle(11'd63,   11'd63,   6'd63, 1'b0);
        send_circle(11'd62,   11'd64,   6'd63, 1'b1);
        send_circle(11'd1024, 11'd5,    6'd2,  1'b0);
        send_circle(11'd5,    11'd1024, 6'd3,  1'b1);
        send_circle(11'd1365, 11'd682,  6'd42, 1'b1);
        send_circle(11'd682,  11'd1365, 6'd21, 1'b0);
        send_circle(11'd790,  11'd10,   6'd0,  1'b1);

        // Random circles over a range of canvas settings, including
        // the smallest, the largest and a zero limit on each axis
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_canvas(1, 1);
                1:       set_canvas(2047, 2047);
                2:       set_canvas(0, $urandom_range(1, 2047));
                3:       set_canvas($urandom_range(1, 2047), 0);
                4:       set_canvas($urandom_range(1, 2047), $urandom_range(1, 2047));
                default: set_canvas(800, 600);
            endcase
            repeat (PHASE_ITEMS)
                send_circle(pick_coord(cur_w), pick_coord(cur_h),
                            RADIUS_W'($urandom_range(0, 63)), 1'($urandom));
        end

        wait_circles_done();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("** midpoint_circle_rasterizer: PASSED **");
        else
            $display("** midpoint_circle_rasterizer: FAILED **");
        $finish;
    end

endmodule
